FILE: src/rcpa_pkg.sv
// Shared constants and types for the reference-counted page allocator.
package rcpa_pkg;

	localparam int PAGE_BITS    = 15;
	localparam int NUM_PAGES    = 1 << PAGE_BITS;
	localparam int DEPTH_BITS   = PAGE_BITS + 1;
	localparam int COUNT_BITS   = 16;
	localparam int CFG_BITS     = 16;
	localparam int CFG_IDX_BITS = 2;
	localparam int KIND_BITS    = 3;
	localparam int STATUS_BITS  = 3;

	localparam logic [KIND_BITS-1:0] KIND_INIT  = 3'd0;
	localparam logic [KIND_BITS-1:0] KIND_ALLOC = 3'd1;
	localparam logic [KIND_BITS-1:0] KIND_FREE  = 3'd2;
	localparam logic [KIND_BITS-1:0] KIND_ADD   = 3'd3;
	localparam logic [KIND_BITS-1:0] KIND_READ  = 3'd4;

	localparam logic [STATUS_BITS-1:0] STAT_OK       = 3'd0;
	localparam logic [STATUS_BITS-1:0] STAT_SHARED   = 3'd1;
	localparam logic [STATUS_BITS-1:0] STAT_OOM      = 3'd2;
	localparam logic [STATUS_BITS-1:0] STAT_BAD_PAGE = 3'd3;
	localparam logic [STATUS_BITS-1:0] STAT_NONPOS   = 3'd4;
	localparam logic [STATUS_BITS-1:0] STAT_FULL     = 3'd5;

	localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_FREE = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_TOP        = 2'd1;

	localparam logic [CFG_BITS-1:0] FIRST_FREE_RESET = 16'd0;
	localparam logic [CFG_BITS-1:0] TOP_RESET        = 16'd32768;

	typedef logic [PAGE_BITS-1:0]         page_t;
	typedef logic [DEPTH_BITS-1:0]        depth_t;
	typedef logic signed [COUNT_BITS-1:0] count_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INIT,
		ST_EXEC
	} state_t;

endpackage

FILE: src/rcpa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module rcpa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/refcounted_page_allocator.sv
// Reference-counted page allocator: count memory, LIFO free stack and control.
//
//   channel  handshake              payload
//   -------  ---------------------  ---------------------------------
//   command  start / busy           kind, page, delta
//   result   done (one-cycle)       status, alloc_page, count
//   config   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Alloc, free, add and read are accepted in idle, read the count memory or the
// stack memory, then modify and write back in the execute state. Alloc on an
// empty stack, free of an out-of-range page and unknown kinds answer straight
// from idle. Init sweeps the count memory, one page a cycle, over all NUM_PAGES
// (32768) pages before its result.
// Reset: a clearing pass zeroes all counts with busy high; config writes are
// taken throughout. The result port cannot be stalled.
module refcounted_page_allocator (
	input  logic                                clk,
	input  logic                                arst_n,
	// command
	input  logic                                start,
	output logic                                busy,
	input  logic [rcpa_pkg::KIND_BITS-1:0]      kind,
	input  logic [rcpa_pkg::PAGE_BITS-1:0]      page,
	input  logic signed [15:0]                  delta,
	// result
	output logic                                done,
	output logic [rcpa_pkg::STATUS_BITS-1:0]    status,
	output logic [rcpa_pkg::PAGE_BITS-1:0]      alloc_page,
	output logic signed [rcpa_pkg::COUNT_BITS-1:0] count,
	// configuration
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rcpa_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [rcpa_pkg::CFG_BITS-1:0]       cfg_data
);

	import rcpa_pkg::*;

	state_t state_q, state_d;

	// configuration registers
	logic [CFG_BITS-1:0] first_free_q;
	logic [CFG_BITS-1:0] top_q;
	logic [CFG_BITS-1:0] eff_top;

	// sweep counter shared by the clearing pass and init
	page_t  sweep_q;
	logic   sweep_last;
	logic   sweep_in_range;
	page_t  sweep_slot;
	depth_t init_depth;

	depth_t depth_q, depth_d;

	// command held through the execute cycle
	logic [KIND_BITS-1:0] op_s1;
	page_t                page_s1;
	logic signed [15:0]   delta_s1;

	logic accept;
	logic free_in_range;

	// memory ports
	logic   cnt_we;
	page_t  cnt_waddr;
	count_t cnt_wdata;
	page_t  cnt_raddr;
	count_t cnt_rdata;
	logic   stk_we;
	page_t  stk_waddr;
	page_t  stk_wdata;
	page_t  stk_raddr;
	page_t  stk_rdata;

	// next result
	logic                   res_valid;
	logic [STATUS_BITS-1:0] res_status;
	page_t                  res_page;
	count_t                 res_count;
	count_t                 dec_count;
	count_t                 sum_count;

	assign cfg_ready = 1'b1;
	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && (state_q == ST_IDLE);

	// clamp top to the number of managed pages
	assign eff_top = (top_q > CFG_BITS'(NUM_PAGES)) ? CFG_BITS'(NUM_PAGES) : top_q;

	assign sweep_last     = &sweep_q;
	assign sweep_in_range = (CFG_BITS'(sweep_q) >= first_free_q) &&
	                        (CFG_BITS'(sweep_q) < eff_top);
	// pages are pushed in ascending order, so page i lands at slot i - first
	assign sweep_slot     = PAGE_BITS'(CFG_BITS'(sweep_q) - first_free_q);
	assign init_depth     = (eff_top > first_free_q) ?
	                        DEPTH_BITS'(eff_top - first_free_q) : '0;

	assign free_in_range  = (CFG_BITS'(page) >= first_free_q) &&
	                        (CFG_BITS'(page) < eff_top);

	assign dec_count = cnt_rdata - count_t'(1);
	assign sum_count = cnt_rdata + count_t'(delta_s1);

	rcpa_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (NUM_PAGES)
	) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	rcpa_ram #(
		.WIDTH (PAGE_BITS),
		.DEPTH (NUM_PAGES)
	) u_stack_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_INIT: begin
				if (sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					case (kind)
						KIND_INIT:  state_d = ST_INIT;
						KIND_ALLOC: state_d = (depth_q != '0) ? ST_EXEC : ST_IDLE;
						KIND_FREE:  state_d = free_in_range ? ST_EXEC : ST_IDLE;
						KIND_ADD:   state_d = ST_EXEC;
						KIND_READ:  state_d = ST_EXEC;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_EXEC: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// memory control, stack depth and result
	always_comb begin
		cnt_we     = 1'b0;
		cnt_waddr  = sweep_q;
		cnt_wdata  = '0;
		cnt_raddr  = page;
		stk_we     = 1'b0;
		stk_waddr  = sweep_slot;
		stk_wdata  = sweep_q;
		stk_raddr  = PAGE_BITS'(depth_q - depth_t'(1));
		depth_d    = depth_q;
		res_valid  = 1'b0;
		res_status = STAT_OK;
		res_page   = '0;
		res_count  = '0;
		case (state_q)
			ST_CLEAR: begin
				cnt_we = 1'b1;
			end
			ST_INIT: begin
				// pages outside the free range end at 1, pages in it drop to 0 and are pushed
				cnt_we    = 1'b1;
				cnt_wdata = sweep_in_range ? count_t'(0) : count_t'(1);
				stk_we    = sweep_in_range;
				if (sweep_last) begin
					depth_d   = init_depth;
					res_valid = 1'b1;
				end
			end
			ST_IDLE: begin
				if (start) begin
					case (kind)
						KIND_ALLOC: begin
							if (depth_q == '0) begin
								res_valid  = 1'b1;
								res_status = STAT_OOM;
							end
						end
						KIND_FREE: begin
							if (!free_in_range) begin
								res_valid  = 1'b1;
								res_status = STAT_BAD_PAGE;
							end
						end
						KIND_INIT, KIND_ADD, KIND_READ: begin
							res_valid = 1'b0;
						end
						default: begin
							res_valid = 1'b1;
						end
					endcase
				end
			end
			ST_EXEC: begin
				res_valid = 1'b1;
				case (op_s1)
					KIND_ALLOC: begin
						// pop: top entry was read in the accept cycle
						cnt_we    = 1'b1;
						cnt_waddr = stk_rdata;
						cnt_wdata = count_t'(1);
						depth_d   = depth_q - depth_t'(1);
						res_page  = stk_rdata;
						res_count = count_t'(1);
					end
					KIND_FREE: begin
						cnt_waddr = page_s1;
						if (cnt_rdata[COUNT_BITS-1] || (cnt_rdata == '0)) begin
							res_status = STAT_NONPOS;
							res_count  = cnt_rdata;
						end else begin
							cnt_we    = 1'b1;
							cnt_wdata = dec_count;
							res_count = dec_count;
							if (!dec_count[COUNT_BITS-1] && (dec_count != '0)) begin
								res_status = STAT_SHARED;
							end else if (depth_q == depth_t'(NUM_PAGES)) begin
								res_status = STAT_FULL;
							end else begin
								stk_we    = 1'b1;
								stk_waddr = depth_q[PAGE_BITS-1:0];
								stk_wdata = page_s1;
								depth_d   = depth_q + depth_t'(1);
							end
						end
					end
					KIND_ADD: begin
						cnt_we    = 1'b1;
						cnt_waddr = page_s1;
						cnt_wdata = sum_count;
						res_count = sum_count;
					end
					KIND_READ: begin
						res_count = cnt_rdata;
					end
					default: begin
						res_count = '0;
					end
				endcase
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			sweep_q      <= '0;
			depth_q      <= '0;
			first_free_q <= FIRST_FREE_RESET;
			top_q        <= TOP_RESET;
			done         <= 1'b0;
		end else begin
			state_q <= state_d;
			depth_q <= depth_d;
			done    <= res_valid;
			// advance the sweep; it wraps back to zero at its end
			if ((state_q == ST_CLEAR) || (state_q == ST_INIT)) begin
				sweep_q <= sweep_q + page_t'(1);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FIRST_FREE: first_free_q <= cfg_data;
					REG_TOP:        top_q        <= cfg_data;
					default:        top_q        <= top_q;
				endcase
			end
		end
	end

	// hold the command and the result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= kind;
			page_s1  <= page;
			delta_s1 <= delta;
		end
		if (res_valid) begin
			status     <= res_status;
			alloc_page <= res_page;
			count      <= res_count;
		end
	end

endmodule
